>>> src/rswr_pkg.sv
`default_nettype none

package rswr_pkg;

    localparam int unsigned WORD_W    = 31;
    localparam int unsigned N_W       = 9;
    localparam int unsigned IDX_W     = 8;
    localparam int unsigned TBL_DEPTH = 256;
    localparam int unsigned CNT_W     = $clog2(WORD_W);
    localparam int unsigned DEF_POOL_SIZE = 256;

    localparam logic REG_POOL_SIZE = 1'b0;
    localparam logic REG_WITH_REPL = 1'b1;

    typedef struct packed {
        logic             clear_all;
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        logic [IDX_W-1:0] wr_data;
    } tbl_ctrl_t;

endpackage

`default_nettype wire

>>> src/rswr_divider.sv
`default_nettype none

module rswr_divider (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [rswr_pkg::WORD_W-1:0] dividend,
    input  wire logic [rswr_pkg::N_W-1:0]  divisor,
    output logic                           done,
    output logic [rswr_pkg::N_W-1:0]       remainder
);
    import rswr_pkg::*;

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [WORD_W-1:0] dvd_reg;
    logic [N_W-1:0]   dsr_reg;
    logic [N_W-1:0]   rem_reg;
    logic [N_W:0]     rem_ext;
    logic [N_W-1:0]   rem_next;

    // one quotient bit per cycle, restoring
    always_comb
    begin
        rem_ext = {rem_reg, dvd_reg[WORD_W-1]};
        if (rem_ext >= {1'b0, dsr_reg})
        begin
            rem_next = N_W'(rem_ext - {1'b0, dsr_reg});
        end
        else
        begin
            rem_next = rem_ext[N_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(WORD_W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[WORD_W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

>>> src/rswr_table.sv
`default_nettype none

module rswr_table (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire rswr_pkg::tbl_ctrl_t    ctrl,
    output logic [rswr_pkg::IDX_W-1:0]  entry
);
    import rswr_pkg::*;

    logic [IDX_W-1:0]     mem [TBL_DEPTH];
    logic [TBL_DEPTH-1:0] written_reg;
    logic [IDX_W-1:0]     rd_data_reg;
    logic [IDX_W-1:0]     rd_addr_reg;
    logic                 rd_written_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            mem[ctrl.wr_addr] <= ctrl.wr_data;
        end
        if (ctrl.rd_en)
        begin
            rd_data_reg <= mem[ctrl.rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.rd_en)
        begin
            rd_addr_reg    <= ctrl.rd_addr;
            rd_written_reg <= written_reg[ctrl.rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg <= '0;
        end
        else if (ctrl.clear_all)
        begin
            written_reg <= '0;
        end
        else if (ctrl.wr_en)
        begin
            written_reg[ctrl.wr_addr] <= 1'b1;
        end
    end

    // unwritten entries read as their own index
    assign entry = rd_written_reg ? rd_data_reg : rd_addr_reg;

endmodule

`default_nettype wire

>>> src/random_sample_without_replacement.sv
// Draws pool indices one item at a time, with or without replacement
// (partial Fisher-Yates shuffle over a 256-entry index table).
// Input channel in_valid/in_ready carries random_word and start_new; each
// item gives exactly one result item on out_valid/out_ready with
// chosen_index and exhausted. Config channel cfg_valid/cfg_ready (always
// ready) writes pool_size (index 0) or with_replacement (index 1) from
// cfg_data; write it only while no draw is in flight.
// Sequence: a draw without replacement runs the bit-serial remainder unit
// (one dividend bit a cycle) and waits for its done flag, then reads
// entry r, reads entry p, writes p and r in turn through the table, and
// loads the output. A draw with replacement goes from the remainder unit
// straight to the output load; an exhausted draw goes straight to it.
// One item is in work at a time and the input reopens in the cycle after
// the result loads.
// Reset clears the written flags, the draw position and the config
// (pool_size 256, without replacement); the table needs no clearing pass.
// If the receiver stalls, the result waits in the output register and the
// block still accepts the next item; a further result waits until the
// output register frees.
`default_nettype none

module random_sample_without_replacement #(
    parameter int unsigned POOL_SIZE = rswr_pkg::DEF_POOL_SIZE
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [rswr_pkg::WORD_W-1:0]  random_word,
    input  wire logic                         start_new,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [rswr_pkg::IDX_W-1:0]        chosen_index,
    output logic                              exhausted,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic                         cfg_index,
    input  wire logic [rswr_pkg::N_W-1:0]     cfg_data
);
    import rswr_pkg::*;

    localparam int unsigned CAP = (POOL_SIZE < TBL_DEPTH) ? POOL_SIZE : TBL_DEPTH;
    localparam logic [N_W-1:0] CAP_N = N_W'(CAP);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_RD_R = 3'd2;
    localparam logic [2:0] ST_RD_P = 3'd3;
    localparam logic [2:0] ST_WR_P = 3'd4;
    localparam logic [2:0] ST_WR_R = 3'd5;
    localparam logic [2:0] ST_FIN  = 3'd6;

    logic [2:0]       state_reg;
    logic [2:0]       state_next;
    logic [N_W-1:0]   pool_size_reg;
    logic             repl_reg;
    logic [N_W-1:0]   pos_reg;
    logic             out_valid_reg;
    logic [IDX_W-1:0] chosen_reg;
    logic             exh_reg;
    logic [IDX_W-1:0] p_reg;
    logic [IDX_W-1:0] r_reg;
    logic [IDX_W-1:0] at_r_reg;
    logic [IDX_W-1:0] at_p_reg;
    logic [IDX_W-1:0] res_idx_reg;
    logic             res_exh_reg;

    logic             in_acc;
    logic             out_free;
    logic [N_W-1:0]   pos_eff;
    logic [N_W-1:0]   n_eff;
    logic             exh_now;
    logic             div_start;
    logic [N_W-1:0]   divisor;
    logic             div_done;
    logic [N_W-1:0]   rem;
    logic [IDX_W-1:0] entry;
    tbl_ctrl_t        tbl_ctrl;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_acc    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        if (pool_size_reg == '0)
        begin
            n_eff = N_W'(1);
        end
        else if (pool_size_reg > CAP_N)
        begin
            n_eff = CAP_N;
        end
        else
        begin
            n_eff = pool_size_reg;
        end
    end

    assign pos_eff   = start_new ? '0 : pos_reg;
    assign exh_now   = !repl_reg && (pos_eff >= n_eff);
    assign div_start = in_acc && !exh_now;
    assign divisor   = repl_reg ? n_eff : N_W'(n_eff - pos_eff);

    rswr_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (random_word),
        .divisor   (divisor),
        .done      (div_done),
        .remainder (rem)
    );

    always_comb
    begin
        tbl_ctrl           = '0;
        tbl_ctrl.clear_all = in_acc && start_new;
        unique case (state_reg)
            ST_RD_R:
            begin
                tbl_ctrl.rd_en   = 1'b1;
                tbl_ctrl.rd_addr = r_reg;
            end
            ST_RD_P:
            begin
                tbl_ctrl.rd_en   = 1'b1;
                tbl_ctrl.rd_addr = p_reg;
            end
            ST_WR_P:
            begin
                tbl_ctrl.wr_en   = 1'b1;
                tbl_ctrl.wr_addr = p_reg;
                tbl_ctrl.wr_data = at_r_reg;
            end
            ST_WR_R:
            begin
                tbl_ctrl.wr_en   = 1'b1;
                tbl_ctrl.wr_addr = r_reg;
                tbl_ctrl.wr_data = at_p_reg;
            end
            default:
            begin
            end
        endcase
    end

    rswr_table u_tbl (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (tbl_ctrl),
        .entry (entry)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = exh_now ? ST_FIN : ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = repl_reg ? ST_FIN : ST_RD_R;
                end
            end
            ST_RD_R: state_next = ST_RD_P;
            ST_RD_P: state_next = ST_WR_P;
            ST_WR_P: state_next = ST_WR_R;
            ST_WR_R: state_next = ST_FIN;
            ST_FIN:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pool_size_reg <= N_W'(TBL_DEPTH);
            repl_reg      <= 1'b0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_POOL_SIZE)
                begin
                    pool_size_reg <= cfg_data;
                end
                else
                begin
                    repl_reg <= cfg_data[0];
                end
            end
            if (in_acc)
            begin
                pos_reg <= pos_eff;
            end
            else if (state_reg == ST_WR_R)
            begin
                pos_reg <= pos_reg + 1'b1;
            end
            if ((state_reg == ST_FIN) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            p_reg       <= pos_eff[IDX_W-1:0];
            res_idx_reg <= '0;
            res_exh_reg <= exh_now;
        end
        if ((state_reg == ST_DIV) && div_done)
        begin
            if (repl_reg)
            begin
                res_idx_reg <= rem[IDX_W-1:0];
            end
            else
            begin
                r_reg <= p_reg + rem[IDX_W-1:0];
            end
        end
        if (state_reg == ST_RD_P)
        begin
            at_r_reg <= entry;
        end
        if (state_reg == ST_WR_P)
        begin
            at_p_reg <= entry;
        end
        if (state_reg == ST_WR_R)
        begin
            res_idx_reg <= at_r_reg;
        end
        if ((state_reg == ST_FIN) && out_free)
        begin
            chosen_reg <= res_idx_reg;
            exh_reg    <= res_exh_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign chosen_index = chosen_reg;
    assign exhausted    = exh_reg;

endmodule

`default_nettype wire

>>> src/rswr_checker.sv
`default_nettype none

module rswr_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic [30:0] random_word,
    input wire logic        start_new,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [7:0]  chosen_index,
    input wire logic        exhausted,
    input wire logic        cfg_valid,
    input wire logic        cfg_ready,
    input wire logic        cfg_index,
    input wire logic [8:0]  cfg_data
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(chosen_index) && $stable(exhausted))
        else $error("result dropped or changed while stalled");

    // one draw in work at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("item accepted while a draw is in work");

    // exhausted result carries index zero
    a_exh_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && exhausted |-> chosen_index == 8'd0)
        else $error("exhausted result with nonzero index");

    // config port never stalls
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("config write stalled");

endmodule

bind random_sample_without_replacement rswr_checker u_rswr_checker (.*);

`default_nettype wire

>>> dv/tb.sv
`default_nettype none

module tb;

    import rswr_pkg::*;

    localparam int unsigned POOL        = 256;
    localparam int unsigned POOL_CAP    = (POOL < TBL_DEPTH) ? POOL : TBL_DEPTH;
    localparam int unsigned TOTAL_DRAWS = 1950;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned STALL_LIMIT = 2000;
    localparam int unsigned TAIL_CYCLES = 60;
    localparam int unsigned MAX_REPORTS = 10;

    typedef enum logic {ROW_DRAW, ROW_CFG} row_kind_t;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic             exh;
    } draw_result_t;

    typedef struct packed {
        row_kind_t         kind;
        logic              reg_sel;
        logic [N_W-1:0]    reg_val;
        logic [WORD_W-1:0] word;
        logic              start;
        logic              typed;
        draw_result_t      res;
    } plan_row_t;

    localparam int unsigned NROWS = 36;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [WORD_W-1:0]   random_word;
    logic                start_new;
    logic                out_valid;
    logic                out_ready;
    logic [IDX_W-1:0]    chosen_index;
    logic                exhausted;
    logic                cfg_valid;
    logic                cfg_ready;
    logic                cfg_index;
    logic [N_W-1:0]      cfg_data;

    // shadow of the shuffle state
    logic [IDX_W-1:0]    shuffle_tbl [TBL_DEPTH];
    bit                  tbl_written [TBL_DEPTH];
    logic [N_W-1:0]      set_pos;
    logic [N_W-1:0]      pool_reg;
    bit                  repl_reg;

    draw_result_t        pending_draws [$];
    int unsigned         err_count;
    int unsigned         mismatch_count;
    int unsigned         draws_sent;
    int unsigned         stall_cycles;
    bit                  hold_req;
    bit                  quiet_stretch;

    plan_row_t plan [NROWS] = '{
        '{ROW_DRAW, 1'b0, 9'd0, 31'd0, 1'b1, 1'b1, '{8'd0, 1'b0}},
        '{ROW_DRAW, 1'b0, 9'd0, 31'h7FFF_FFFF, 1'b0, 1'b0, '{8'd0, 1'b0}},
        '{ROW_DRAW, 1'b0, 9'd0, 31'h7FFF_FFFF, 1'b1, 1'b1, '{8'd255, 1'b0}},
        '{ROW_DRAW, 1'b0, 9'd0, 31'h5555_5555, 1'b0, 1'b0, '{8'd0, 1'b0}},
        '{ROW_CFG, REG_POOL_SIZE, 9'd1, 31'd0, 1'b0, 1'b0, '{8'd0, 1'b0}},
        '{ROW_DRAW, 1'b0, 9'd0, 31'h2AAA_AAAA, 1'b1, 1'b1, '{8'd0, 1'b0}},
        '{ROW_DRAW, 1'b0, 9'd0, 31'd5, 1'b0, 1'b1, '{8'd0, 1'b1}},
        '{ROW_DRAW, 1'b0, 9'd0, 31'h7FFF_FFFF, 1'b0, 1'b1, '{8'd0, 1'b1}},
        '{ROW_CFG, REG_POOL_SIZE, 9'd0, 31'd0, 1'b0, 1'b0, '{8'd0, 1'b0}},
        '{ROW_DRAW, 1'b0, 9'd0, 31'd123, 1'b1, 1'b1, '{8'd0, 1'b0}},
        '{ROW_DRAW, 1'b0, 9'd0, 31'd0, 1'b0, 1'b1, '{8'd0, 1'b1}},
        '{ROW_CFG, REG_POOL_SIZE, 9'd2, 31'd0, 1'b0, 1'b0, '{8'd0, 1'b0}},
        '{ROW_DRAW, 1'b0, 9'd0, 31'd1, 1'b1, 1'b1, '{8'd1, 1'b0}},
        '{ROW_DRAW, 1'b0, 9'd0, 31'd0, 1'b0, 1'b0, '{8'd0, 1'b0}},
        '{ROW_DRAW, 1'b0, 9'd0, 31'd7, 1'b0, 1'b1, '{8'd0, 1'b1}},
        '{ROW_DRAW, 1'b0, 9'd0, 31'd0, 1'b1, 1'b1, '{8'd0, 1'b0}},
        '{ROW_CFG, REG_POOL_SIZE, 9'd511, 31'd0, 1'b0, 1'b0, '{8'd0, 1'b0}},
        '{ROW_DRAW, 1'b0, 9'd0, 31'h7FFF_FFFF, 1'b1, 1'b1, '{8'd255, 1'b0}},
        '{ROW_DRAW, 1'b0, 9'd0, 31'd1, 1'b0, 1'b0, '{8'd0, 1'b0}},
        '{ROW_CFG, REG_WITH_REPL, 9'd1, 31'd0, 1'b0, 1'b0, '{8'd0, 1'b0}},
        '{ROW_DRAW, 1'b0, 9'd0, 31'h7FFF_FFFF, 1'b1, 1'b1, '{8'd255, 1'b0}},
        '{ROW_DRAW, 1'b0, 9'd0, 31'd259, 1'b0, 1'b1, '{8'd3, 1'b0}},
        '{ROW_CFG, REG_POOL_SIZE, 9'd300, 31'd0, 1'b0, 1'b0, '{8'd0, 1'b0}},
        '{ROW_DRAW, 1'b0, 9'd0, 31'h0001_2345, 1'b0, 1'b0, '{8'd0, 1'b0}},
        '{ROW_CFG, REG_POOL_SIZE, 9'd0, 31'd0, 1'b0, 1'b0, '{8'd0, 1'b0}},
        '{ROW_DRAW, 1'b0, 9'd0, 31'h7FFF_FFFF, 1'b0, 1'b1, '{8'd0, 1'b0}},
        '{ROW_CFG, REG_POOL_SIZE, 9'd200, 31'd0, 1'b0, 1'b0, '{8'd0, 1'b0}},
        '{ROW_DRAW, 1'b0, 9'd0, 31'h4000_0000, 1'b0, 1'b0, '{8'd0, 1'b0}},
        '{ROW_CFG, REG_WITH_REPL, 9'd0, 31'd0, 1'b0, 1'b0, '{8'd0, 1'b0}},
        '{ROW_CFG, REG_POOL_SIZE, 9'd3, 31'd0, 1'b0, 1'b0, '{8'd0, 1'b0}},
        '{ROW_DRAW, 1'b0, 9'd0, 31'd0, 1'b0, 1'b0, '{8'd0, 1'b0}},
        '{ROW_DRAW, 1'b0, 9'd0, 31'd9, 1'b0, 1'b0, '{8'd0, 1'b0}},
        '{ROW_CFG, REG_POOL_SIZE, 9'd2, 31'd0, 1'b0, 1'b0, '{8'd0, 1'b0}},
        '{ROW_DRAW, 1'b0, 9'd0, 31'd0, 1'b0, 1'b0, '{8'd0, 1'b0}},
        '{ROW_CFG, REG_POOL_SIZE, 9'd256, 31'd0, 1'b0, 1'b0, '{8'd0, 1'b0}},
        '{ROW_DRAW, 1'b0, 9'd0, 31'h7FFF_FFFF, 1'b0, 1'b0, '{8'd0, 1'b0}}
    };

    random_sample_without_replacement #(
        .POOL_SIZE (POOL)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .random_word  (random_word),
        .start_new    (start_new),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .chosen_index (chosen_index),
        .exhausted    (exhausted),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic int unsigned eff_pool(input logic [N_W-1:0] v);
        int unsigned n;
        n = (v == 0) ? 1 : v;
        if (n > POOL_CAP)
        begin
            n = POOL_CAP;
        end
        return n;
    endfunction

    function automatic draw_result_t predict_draw(input logic [WORD_W-1:0] w, input logic s);
        draw_result_t res;
        int unsigned  n;
        int unsigned  p;
        int unsigned  r;
        int unsigned  at_r;
        int unsigned  at_p;
        int unsigned  pick;
        res = '0;
        n = eff_pool(pool_reg);
        if (s)
        begin
            foreach (tbl_written[i])
            begin
                tbl_written[i] = 1'b0;
            end
            set_pos = '0;
        end
        if (repl_reg)
        begin
            pick = w % n;
            res.idx = pick[IDX_W-1:0];
        end
        else if (set_pos >= n)
        begin
            res.exh = 1'b1;
        end
        else
        begin
            p = set_pos;
            r = p + w % (n - p);
            at_r = tbl_written[r] ? shuffle_tbl[r] : r;
            at_p = tbl_written[p] ? shuffle_tbl[p] : p;
            res.idx = at_r[IDX_W-1:0];
            shuffle_tbl[p] = at_r[IDX_W-1:0];
            shuffle_tbl[r] = at_p[IDX_W-1:0];
            tbl_written[p] = 1'b1;
            tbl_written[r] = 1'b1;
            set_pos = set_pos + 1'b1;
        end
        return res;
    endfunction

    task automatic send_draw(input logic [WORD_W-1:0] w, input logic s,
                             input logic typed, input draw_result_t typed_res);
        draw_result_t predicted;
        in_valid    <= 1'b1;
        random_word <= w;
        start_new   <= s;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        predicted = predict_draw(w, s);
        pending_draws.push_back(typed ? typed_res : predicted);
        draws_sent++;
    endtask

    task automatic maybe_idle();
        if (!quiet_stretch && $urandom_range(99) < 15)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_draws.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic sel, input logic [N_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        if (sel == REG_POOL_SIZE)
        begin
            pool_reg = v;
        end
        else
        begin
            repl_reg = v[0];
        end
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            default: return WORD_W'($urandom);
        endcase
    endfunction

    function automatic logic [N_W-1:0] pick_pool();
        case ($urandom_range(0, 9))
            0:       return 9'd0;
            1:       return 9'd1;
            2:       return 9'd256;
            3:       return N_W'($urandom_range(257, 511));
            4:       return N_W'($urandom_range(17, 255));
            default: return N_W'($urandom_range(2, 16));
        endcase
    endfunction

    // result checker
    always @(posedge clk)
    begin
        draw_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_draws.size() == 0)
            begin
                err_count++;
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                begin
                    $display("unexpected item: index %0d exhausted %0d", chosen_index, exhausted);
                end
            end
            else
            begin
                want = pending_draws.pop_front();
                if (chosen_index !== want.idx || exhausted !== want.exh)
                begin
                    err_count++;
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                    begin
                        $display("mismatch: expected index %0d exhausted %0d, got index %0d exhausted %0d",
                                 want.idx, want.exh, chosen_index, exhausted);
                    end
                end
            end
        end
    end

    // watchdog on cycles with no item accepted anywhere
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // receiver
    initial
    begin
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            out_ready <= quiet_stretch || ($urandom_range(99) >= 15);
        end
    end

    // sender
    initial
    begin
        int unsigned   n;
        int unsigned   nsets;
        int unsigned   len;
        logic [N_W-1:0] pool_v;
        logic          repl_v;
        logic          carry_on;
        logic          s;

        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        random_word <= '0;
        start_new   <= 1'b0;
        cfg_valid   <= 1'b0;
        cfg_index   <= REG_POOL_SIZE;
        cfg_data    <= '0;
        draws_sent     = 0;
        hold_req       = 1'b0;
        quiet_stretch  = 1'b0;
        pool_reg       = 9'd256;
        repl_reg       = 1'b0;
        set_pos        = '0;
        foreach (tbl_written[i])
        begin
            tbl_written[i] = 1'b0;
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < NROWS; i++)
        begin
            if (plan[i].kind == ROW_CFG)
            begin
                drain_results();
                write_reg(plan[i].reg_sel, plan[i].reg_val);
            end
            else
            begin
                send_draw(plan[i].word, plan[i].start, plan[i].typed, plan[i].res);
                maybe_idle();
            end
        end

        while (draws_sent < TOTAL_DRAWS)
        begin
            drain_results();
            pool_v = pick_pool();
            repl_v = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 1))
            begin
                write_reg(REG_POOL_SIZE, pool_v);
                write_reg(REG_WITH_REPL, {{(N_W-1){1'b0}}, repl_v});
            end
            else
            begin
                write_reg(REG_WITH_REPL, {{(N_W-1){1'b0}}, repl_v});
                write_reg(REG_POOL_SIZE, pool_v);
            end
            n = eff_pool(pool_v);
            nsets = $urandom_range(1, 3);
            // sometimes keep the old set going under the new pool size
            carry_on = ($urandom_range(99) < 25);
            for (int k = 0; k < nsets && draws_sent < TOTAL_DRAWS; k++)
            begin
                len = repl_v ? $urandom_range(1, 8) : $urandom_range(1, n + 2);
                for (int j = 0; j < len && draws_sent < TOTAL_DRAWS; j++)
                begin
                    s = (j == 0 && !(k == 0 && carry_on)) || ($urandom_range(99) < 3);
                    send_draw(pick_word(), s, 1'b0, '0);
                    maybe_idle();
                    quiet_stretch = (draws_sent >= 700 && draws_sent < 1000);
                    if (draws_sent == 500)
                    begin
                        hold_req = 1'b1;
                    end
                    if (draws_sent == 1200)
                    begin
                        drain_results();
                    end
                end
            end
        end

        in_valid <= 1'b0;
        while (pending_draws.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        if (err_count == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

`default_nettype wire
